// File: rtl/core/vit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vit_pkg: shared types and constants of the voxel interior trim block
// Plane geometry, field widths, register indexes, the request / response
// structs between the control logic and the plane store, and the result item.
// ----------------------------------------------------------------------------
package vit_pkg;

  // plane geometry
  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROWS_W   = ROW_W + 1;
  localparam int COLS_W   = COL_W + 1;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = 1 << ADDR_W;

  // field and register widths
  localparam int VOX_W      = 8;
  localparam int PLANE_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_YZ_W  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // access request to the plane store
  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VOX_W-1:0]  wr_value;
    logic              wr_lower;
  } vit_store_req_t;

  // registered read data around the requested cell
  typedef struct packed {
    logic             valid;
    logic [VOX_W-1:0] center;
    logic             lower_center;
    logic             solid_down;
    logic             solid_right;
    logic             lower_up;
  } vit_store_rsp_t;

  // one result item
  typedef struct packed {
    logic [VOX_W-1:0] voxel;
    logic             trimmed;
    logic             last;
  } vit_result_t;

endpackage

// File: rtl/core/voxel_interior_trim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_interior_trim: streaming removal of hidden voxels
// Clears interior voxels whose six face neighbors are all solid.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one voxel per request, z fastest, then y, then x.
//   s_tuser marks a drain request; after the last plane drain requests push
//   out the final plane. Each voxel comes back one plane later on the master
//   stream; m_tuser flags a trimmed voxel and m_tlast the final voxel.
//   The size registers must be written by the user on the plain write port
//   while idle; the block does not enforce it.
// Throughput: one request per cycle while the store read is valid and the
//   skid register is empty. The plane store is read one cell ahead from the
//   position counters, so the memory read latency is hidden; with a row length
//   of one the write meets a read-ahead address and s_tready drops after each
//   request, and a single row of two voxels drops it at each plane wrap.
// Reset:
//   Sizes return to 128 each and the counters to the volume start. The
//   store is not cleared; s_tready rises with the first valid store read.
// Stall:
//   When the receiver stalls, one more result goes to a skid register, then
//   s_tready drops until the master register is taken.
// ----------------------------------------------------------------------------
module voxel_interior_trim (
  input  logic                           clk,
  input  logic                           rst,
  // slave stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [vit_pkg::VOX_W-1:0]      s_tdata,   // [7:0] voxel_value
  input  logic                           s_tuser,   // [0] drain
  // master stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [vit_pkg::VOX_W-1:0]      m_tdata,   // [7:0] voxel_out
  output logic                           m_tuser,   // [0] was_trimmed
  output logic                           m_tlast,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [vit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vit_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vit_pkg::*;

  logic [PLANE_W-1:0]   size_x;
  logic [SIZE_YZ_W-1:0] size_y;
  logic [SIZE_YZ_W-1:0] size_z;
  logic [PLANE_W-1:0]   eff_x;
  logic [ROWS_W-1:0]    eff_y;
  logic [COLS_W-1:0]    eff_z;

  logic [PLANE_W-1:0]   plane;
  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic [PLANE_W-1:0]   plane_next;
  logic [ROW_W-1:0]     row_next;
  logic [COL_W-1:0]     col_next;
  logic [ROWS_W-1:0]    row_inc;
  logic [COLS_W-1:0]    col_inc;
  logic                 prev_lower;

  logic                 accept;
  logic                 drain_phase;
  logic                 step;
  logic                 produce;
  logic                 interior;
  logic                 trim;
  logic                 end_of_volume;
  logic                 out_fire;
  logic                 skid_valid;
  vit_result_t          result;
  vit_result_t          skid;
  vit_store_req_t       store_req;
  vit_store_rsp_t       store_rsp;

  // effective sizes
  always_comb begin
    eff_x = (size_x == '0) ? PLANE_W'(1) : size_x;
    if (size_y == '0) begin
      eff_y = ROWS_W'(1);
    end else if ({1'b0, size_y} > CFG_DATA_W'(MAX_ROWS)) begin
      eff_y = ROWS_W'(MAX_ROWS);
    end else begin
      eff_y = ROWS_W'(size_y);
    end
    if (size_z == '0) begin
      eff_z = COLS_W'(1);
    end else if ({1'b0, size_z} > CFG_DATA_W'(MAX_COLS)) begin
      eff_z = COLS_W'(MAX_COLS);
    end else begin
      eff_z = COLS_W'(size_z);
    end
  end

  // request handshake and item kind
  assign s_tready    = store_rsp.valid && !skid_valid && !rst;
  assign accept      = s_tvalid && s_tready;
  assign drain_phase = plane >= eff_x;
  assign step        = accept && (drain_phase || !s_tuser);
  assign produce     = step && (plane != '0);
  assign out_fire    = m_tvalid && m_tready;
  assign row_inc     = ROWS_W'(row) + ROWS_W'(1);
  assign col_inc     = COLS_W'(col) + COLS_W'(1);

  // trim decision
  always_comb begin
    interior = (plane >= PLANE_W'(2)) && !drain_phase &&
               (row != '0) && (row_inc < eff_y) &&
               (col != '0) && (col_inc < eff_z);
    trim = interior && (store_rsp.center != '0) && store_rsp.lower_center &&
           (s_tdata != '0) && store_rsp.lower_up && store_rsp.solid_down &&
           prev_lower && store_rsp.solid_right;
    end_of_volume  = drain_phase && (row_inc >= eff_y) && (col_inc >= eff_z);
    result.voxel   = trim ? '0 : store_rsp.center;
    result.trimmed = trim;
    result.last    = end_of_volume;
  end

  // next position
  always_comb begin
    plane_next = plane;
    row_next   = row;
    col_next   = col[COL_W-1:0];
    if (col_inc >= eff_z) begin
      col_next = '0;
      if (row_inc >= eff_y) begin
        row_next   = '0;
        plane_next = drain_phase ? '0 : plane + PLANE_W'(1);
      end else begin
        row_next = row_inc[ROW_W-1:0];
      end
    end else begin
      col_next = col_inc[COL_W-1:0];
    end
    if (end_of_volume) begin
      plane_next = '0;
      row_next   = '0;
      col_next   = '0;
    end
  end

  // store access: read ahead at the position of the next request
  always_comb begin
    store_req.rd_addr  = step ? {row_next, col_next} : {row, col};
    store_req.wr_en    = step && !drain_phase;
    store_req.wr_addr  = {row, col};
    store_req.wr_value = s_tdata;
    store_req.wr_lower = store_rsp.center != '0;
  end

  vit_plane_store u_store (
    .clk (clk),
    .rst (rst),
    .req (store_req),
    .rsp (store_rsp)
  );

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= PLANE_W'(128);
      size_y <= SIZE_YZ_W'(128);
      size_z <= SIZE_YZ_W'(128);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_X: size_x <= cfg_data;
        CFG_SIZE_Y: size_y <= cfg_data[SIZE_YZ_W-1:0];
        CFG_SIZE_Z: size_z <= cfg_data[SIZE_YZ_W-1:0];
        default: ;
      endcase
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
      row   <= '0;
      col   <= '0;
    end else if (step) begin
      plane <= plane_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

  // lower solid bit of the cell just before the current one
  always_ff @(posedge clk) begin
    if (step) begin
      prev_lower <= drain_phase ? store_rsp.lower_center : (store_rsp.center != '0);
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (produce) begin
      if (!m_tvalid || out_fire) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        m_tdata <= skid.voxel;
        m_tuser <= skid.trimmed;
        m_tlast <= skid.last;
      end
    end else if (produce) begin
      if (!m_tvalid || out_fire) begin
        m_tdata <= result.voxel;
        m_tuser <= result.trimmed;
        m_tlast <= result.last;
      end else begin
        skid <= result;
      end
    end
  end

endmodule

// File: rtl/core/vit_plane_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vit_plane_store: plane memories of the voxel interior trim block
// Two synchronous memories hold the previous plane values with the solid
// bits of the plane before; four registered reads cover a cell and its
// neighbors, and a read that collides with the write is flagged invalid.
// ----------------------------------------------------------------------------
module vit_plane_store (
  input  logic                     clk,
  input  logic                     rst,
  input  vit_pkg::vit_store_req_t  req,
  output vit_pkg::vit_store_rsp_t  rsp
);
  import vit_pkg::*;

  // {lower solid, middle value} per cell
  logic [VOX_W:0]    val_mem [DEPTH];
  // {middle solid, lower solid} per cell, second copy for extra read ports
  logic [1:0]        flag_mem [DEPTH];

  logic [ROW_W-1:0]  rd_row;
  logic [COL_W-1:0]  rd_col;
  logic [ADDR_W-1:0] addr_right;
  logic [ADDR_W-1:0] addr_down;
  logic [ADDR_W-1:0] addr_up;
  logic              hazard;
  logic [VOX_W:0]    val_a;
  logic [VOX_W-1:0]  val_b;
  logic [1:0]        flag_a;
  logic [1:0]        flag_b;
  logic              rd_valid;

  // neighbor addresses
  assign rd_row     = req.rd_addr[ADDR_W-1:COL_W];
  assign rd_col     = req.rd_addr[COL_W-1:0];
  assign addr_right = req.rd_addr + ADDR_W'(1);
  assign addr_down  = {rd_row + ROW_W'(1), rd_col};
  assign addr_up    = {rd_row - ROW_W'(1), rd_col};

  // read of a cell being written this cycle
  assign hazard = req.wr_en && ((req.rd_addr == req.wr_addr) ||
                                (addr_right == req.wr_addr) ||
                                (addr_down == req.wr_addr) ||
                                (addr_up == req.wr_addr));

  // memory ports, read before write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      val_mem[req.wr_addr]  <= {req.wr_lower, req.wr_value};
      flag_mem[req.wr_addr] <= {req.wr_value != '0, req.wr_lower};
    end
    val_a  <= val_mem[req.rd_addr];
    val_b  <= val_mem[addr_down][VOX_W-1:0];
    flag_a <= flag_mem[addr_right];
    flag_b <= flag_mem[addr_up];
  end

  // read data validity
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= !hazard;
    end
  end

  // response
  assign rsp.valid        = rd_valid;
  assign rsp.center       = val_a[VOX_W-1:0];
  assign rsp.lower_center = val_a[VOX_W];
  assign rsp.solid_down   = val_b != '0;
  assign rsp.solid_right  = flag_a[1];
  assign rsp.lower_up     = flag_b[0];

endmodule

// File: rtl/core/vit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vit_checker: port checks of the voxel interior trim block
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module vit_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [vit_pkg::VOX_W-1:0] m_tdata,
  input logic                      m_tuser,
  input logic                      m_tlast
);
  import vit_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

  // store read data not ready right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !s_tready)
    else $error("request taken before first store read");

  // a trimmed voxel comes out as empty
  a_trim_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("trimmed voxel not cleared");

  // the final voxel lies on a face and is never trimmed
  a_last_kept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser)
    else $error("final voxel flagged as trimmed");

endmodule

bind voxel_interior_trim vit_checker u_vit_checker (.*);

// File: tb/vit_trim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vit_trim_checker: result checker for voxel_interior_trim
// Watches the request, result and register ports. Keeps its own copy of the
// size registers, the two plane stores and the position counters, predicts
// the trimmed voxel for each accepted request and compares every accepted
// result with the oldest predicted voxel.
// ----------------------------------------------------------------------------
module vit_trim_checker (
  input  logic                           clk,
  input  logic                           rst,
  // request side
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [vit_pkg::VOX_W-1:0]      s_tdata,
  input  logic                           s_tuser,
  // result side
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [vit_pkg::VOX_W-1:0]      m_tdata,
  input  logic                           m_tuser,
  input  logic                           m_tlast,
  // register writes
  input  logic                           cfg_we,
  input  logic [vit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vit_pkg::CFG_DATA_W-1:0] cfg_data,
  // status toward the top
  output int                             err_count,
  output int                             pending,
  output int                             results_seen,
  output int                             trims_seen
);
  import vit_pkg::*;

  // shadow registers and plane stores
  logic [PLANE_W-1:0]   size_x_q;
  logic [SIZE_YZ_W-1:0] size_y_q;
  logic [SIZE_YZ_W-1:0] size_z_q;
  logic [VOX_W-1:0]     mid_plane [DEPTH];
  bit                   low_solid [DEPTH];
  int unsigned          plane_cnt;
  int unsigned          row_cnt;
  int unsigned          col_cnt;
  vit_result_t          expected_voxels [$];
  vit_result_t          want_voxel;

  initial begin
    foreach (mid_plane[i]) mid_plane[i] = '0;
  end

  // zero acts as one, oversize acts as the maximum
  function automatic int unsigned clip_size(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // trim decision for one request, then store update and counter advance
  task automatic predict_trim(input logic [VOX_W-1:0] value, input logic drain);
    int unsigned ex, ey, ez, x, y, z, idx;
    bit          draining, solid_now, interior, trim, vol_end;
    vit_result_t r;
    ex       = clip_size(size_x_q, 511);
    ey       = clip_size(size_y_q, MAX_ROWS);
    ez       = clip_size(size_z_q, MAX_COLS);
    draining = plane_cnt >= ex;
    // a drain before the volume is complete is dropped
    if (!draining && drain) return;
    x         = plane_cnt;
    y         = (row_cnt >= MAX_ROWS) ? MAX_ROWS - 1 : row_cnt;
    z         = (col_cnt >= MAX_COLS) ? MAX_COLS - 1 : col_cnt;
    idx       = y * MAX_COLS + z;
    solid_now = !draining && value != 0;
    vol_end   = 1'b0;
    // the voxel one plane back comes out once plane 1 is under way
    if (x >= 1) begin
      interior = x >= 2 && x < ex && y >= 1 && y + 1 < ey && z >= 1 && z + 1 < ez;
      trim = interior && mid_plane[idx] != 0 && low_solid[idx] && solid_now &&
             low_solid[idx - MAX_COLS] && mid_plane[idx + MAX_COLS] != 0 &&
             low_solid[idx - 1] && mid_plane[idx + 1] != 0;
      vol_end   = draining && y + 1 >= ey && z + 1 >= ez;
      r.voxel   = trim ? '0 : mid_plane[idx];
      r.trimmed = trim;
      r.last    = vol_end;
      expected_voxels.push_back(r);
    end
    if (!draining) begin
      low_solid[idx] = mid_plane[idx] != 0;
      mid_plane[idx] = value;
    end
    // raster advance, z fastest
    z = col_cnt + 1;
    y = row_cnt;
    if (z >= ez) begin
      z = 0;
      y = row_cnt + 1;
      if (y >= ey) begin
        y = 0;
        x = draining ? 0 : (plane_cnt + 1) & 'h1FF;
      end
    end
    if (vol_end) begin
      x = 0;
      y = 0;
      z = 0;
    end
    plane_cnt = x;
    row_cnt   = y;
    col_cnt   = z;
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      size_x_q     = 9'd128;
      size_y_q     = 8'd128;
      size_z_q     = 8'd128;
      plane_cnt    = 0;
      row_cnt      = 0;
      col_cnt      = 0;
      err_count    = 0;
      results_seen = 0;
      trims_seen   = 0;
      expected_voxels.delete();
    end else begin
      // result compare against the oldest prediction
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tuser === 1'b1) trims_seen++;
        if (expected_voxels.size() == 0) begin
          $error("unexpected result: voxel_out %0d was_trimmed %0b last %0b",
                 m_tdata, m_tuser, m_tlast);
          err_count++;
        end else begin
          want_voxel = expected_voxels.pop_front();
          if (m_tdata !== want_voxel.voxel) begin
            $error("voxel_out: expected %0d, actual %0d", want_voxel.voxel, m_tdata);
            err_count++;
          end
          if (m_tuser !== want_voxel.trimmed) begin
            $error("was_trimmed: expected %0b, actual %0b", want_voxel.trimmed, m_tuser);
            err_count++;
          end
          if (m_tlast !== want_voxel.last) begin
            $error("last: expected %0b, actual %0b", want_voxel.last, m_tlast);
            err_count++;
          end
        end
      end
      // new request
      if (s_tvalid && s_tready) predict_trim(s_tdata, s_tuser);
      // register write
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE_X: size_x_q = cfg_data[PLANE_W-1:0];
          CFG_SIZE_Y: size_y_q = cfg_data[SIZE_YZ_W-1:0];
          CFG_SIZE_Z: size_z_q = cfg_data[SIZE_YZ_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_voxels.size();
  end

endmodule

// File: tb/tb_voxel_interior_trim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_interior_trim: stimulus and verdict for voxel_interior_trim
// Streams whole volumes through the block: a few hand-made tiny volumes,
// a sweep over the size extremes, then random volumes with dense content so
// that interior voxels get trimmed. Requests come in bursts, the result side
// stalls on its own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_voxel_interior_trim;
  import vit_pkg::*;

  localparam int HOLD_CYCLES = 300;
  // longest legal quiet stretch is the long hold plus a gap and a stall
  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 250;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [VOX_W-1:0]      s_tdata;   // [7:0] voxel_value
  logic                  s_tuser;   // [0] drain
  logic                  m_tvalid;
  logic                  m_tready;
  logic [VOX_W-1:0]      m_tdata;   // [7:0] voxel_out
  logic                  m_tuser;   // [0] was_trimmed
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int check_errors;
  int check_pending;
  int results_seen;
  int trims_seen;
  int burst_left;
  int total_requests;
  int random_items;
  int volumes;
  int stuck_cycles;
  bit want_hold;
  bit hold_done;

  voxel_interior_trim uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  vit_trim_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .err_count   (check_errors),
    .pending     (check_pending),
    .results_seen(results_seen),
    .trims_seen  (trims_seen)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // one request, with a random gap at the start of each burst
  task automatic push_request(input logic [VOX_W-1:0] value, input logic drain);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= drain;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    total_requests++;
  endtask

  // write the three size registers back to back
  task automatic set_sizes(input int nx, input int ny, input int nz);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SIZE_X;
    cfg_data  <= CFG_DATA_W'(nx);
    @(negedge clk);
    cfg_index <= CFG_SIZE_Y;
    cfg_data  <= CFG_DATA_W'(ny);
    @(negedge clk);
    cfg_index <= CFG_SIZE_Z;
    cfg_data  <= CFG_DATA_W'(nz);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stop offering and let the final plane drain out
  task automatic finish_volume();
    s_tvalid <= 1'b0;
    while (check_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    volumes++;
  endtask

  function automatic int clip_size(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // one full volume of random content followed by its drain plane
  task automatic run_volume(input int nx, input int ny, input int nz,
                            input int fill_pct, input int stray_pct);
    int ex, ey, ez, n;
    ex = clip_size(nx % 512, 511);
    ey = clip_size(ny % 256, MAX_ROWS);
    ez = clip_size(nz % 256, MAX_COLS);
    set_sizes(nx, ny, nz);
    for (n = 0; n < ex * ey * ez; n++) begin
      // stray drains before the volume is complete are dropped by the block
      if ($urandom_range(0, 99) < stray_pct) push_request(VOX_W'($urandom), 1'b1);
      if ($urandom_range(0, 99) < fill_pct)
        push_request(VOX_W'($urandom_range(1, 255)), 1'b0);
      else
        push_request('0, 1'b0);
    end
    // drain plane, sometimes with plain voxels that count as drains
    for (n = 0; n < ey * ez; n++)
      push_request(VOX_W'($urandom), $urandom_range(0, 99) < 85);
    finish_volume();
    random_items += ex * ey * ez + ey * ez;
  endtask

  // result side stall pattern, with one long hold-off
  initial begin : receiver
    int seg, mode, pct;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (want_hold && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(4, 40);
        pct  = 30;
        if (mode == 0) pct = 0;
        if (mode == 3) begin
          pct = 100;
          seg = $urandom_range(1, 20);
        end
        repeat (seg) begin
          m_tready <= ($urandom_range(0, 99) >= pct);
          @(negedge clk);
        end
      end
    end
  end

  // watchdog on stretches without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout after %0d quiet cycles", stuck_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int nx, ny, nz;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SIZE_X;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single voxel: stray drain, voxel, then a plain voxel acting as drain
    set_sizes(1, 1, 1);
    push_request(8'hFF, 1'b1);
    push_request(8'hFF, 1'b0);
    push_request(8'h5A, 1'b0);
    finish_volume();

    // zero sizes act as one
    set_sizes(0, 0, 0);
    push_request(8'h00, 1'b0);
    push_request(8'hA5, 1'b1);
    finish_volume();

    // two planes of two voxels, value extremes, stray drain between planes
    set_sizes(2, 1, 2);
    push_request(8'h01, 1'b0);
    push_request(8'h80, 1'b0);
    push_request(8'h00, 1'b1);
    push_request(8'hFE, 1'b0);
    push_request(8'h00, 1'b0);
    push_request(8'hFF, 1'b1);
    push_request(8'h7F, 1'b1);
    finish_volume();

    // size extremes, including oversize rows and columns
    run_volume(256, 1, 1, 90, 3);
    run_volume(1, 255, 1, 80, 3);
    run_volume(1, 1, 255, 80, 3);

    // random volumes, mostly dense so that interiors get trimmed
    want_hold    = 1'b1;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        nx = $urandom_range(3, 6);
        ny = $urandom_range(3, 6);
        nz = $urandom_range(3, 6);
        run_volume(nx, ny, nz, 92, 4);
      end else begin
        nx = $urandom_range(0, 6);
        ny = $urandom_range(0, 6);
        nz = $urandom_range(0, 6);
        run_volume(nx, ny, nz, $urandom_range(20, 95), 8);
      end
    end

    // settle and report
    repeat (16) @(negedge clk);
    $display("covered %0d requests in %0d volumes, sizes from one voxel to 256 planes",
             total_requests, volumes);
    $display("and 128-voxel rows and columns; %0d results checked, %0d trimmed",
             results_seen, trims_seen);
    if (check_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
